// ===== rtl/slr1_pkg.sv =====
package slr1_pkg;

   localparam int DEF_NUM_STATES   = 512;
   localparam int DEF_NUM_SYMBOLS  = 64;
   localparam int DEF_NUM_RULES    = 128;
   localparam int DEF_STACK_DEPTH  = 256;
   localparam int MAX_REDUCTIONS   = 62;
   localparam logic [5:0] ACCEPT_SYMBOL_RESET = 6'd63;

   typedef enum logic [2:0] {
      MODE_TOKEN      = 3'd0,
      MODE_END        = 3'd1,
      MODE_WRITE_TRN  = 3'd2,
      MODE_WRITE_RED  = 3'd3,
      MODE_WRITE_RULE = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_REDUCED  = 3'd0,
      KIND_SHIFTED  = 3'd1,
      KIND_REJECTED = 3'd2,
      KIND_ACCEPTED = 3'd3,
      KIND_WRITTEN  = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RED_ISSUE,
      ST_RED_DATA,
      ST_RULE_DATA,
      ST_STK_DATA,
      ST_GOTO_DATA,
      ST_SHIFT_DATA,
      ST_END_DATA,
      ST_END_STK,
      ST_END_ACC,
      ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [5:0] symbol;
      logic [8:0] state_num;
      logic [8:0] target;
      logic       entry_valid;
      logic [5:0] rule_lhs;
      logic [3:0] rule_length;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] rule_number;
      logic [8:0] new_top_state;
      logic       last;
   } rsp_payload_type;

endpackage

// ===== rtl/slr1_req_if.sv =====
interface slr1_req_if import slr1_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/slr1_rsp_if.sv =====
interface slr1_rsp_if import slr1_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/slr1_shift_reduce_parser.sv =====
// Table-driven SLR(1) shift-reduce parser.
// req_if carries one request per handshake: a token, end of input, or a
// write into the transition, reduction or rule table. rsp_if returns the
// results of a request in order; the final one has last set.
// csr_we/csr_wdata load the accept symbol; the user must load it only while
// the block is idle, which the block does not enforce. A table write or a
// token refused while an error is pending answers one registered result.
// Each reduction of a token steps through reduction, rule, stack and goto
// reads and a push, then a response; the final shift pushes the transition
// target. End of input answers a reject, or a reduce and an accept. All
// reads go through one sequencer and one read port per table, so one
// request is in work at a time and req_if.ready is low until it finishes.
// After reset both lookup tables are cleared, one entry a cycle, over all
// NUM_STATES*NUM_SYMBOLS entries (32768 by default); requests wait, csr
// writes are taken. The stack holds state 0 and the error flag is clear.
// When rsp_if.ready is low the result is held and the sequencer waits.
module slr1_shift_reduce_parser import slr1_pkg::*; #(
   parameter int NUM_STATES  = DEF_NUM_STATES,
   parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
   parameter int NUM_RULES   = DEF_NUM_RULES,
   parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   slr1_req_if.sink   req_if,
   slr1_rsp_if.source rsp_if,
   input  logic       csr_we,
   input  logic [5:0] csr_wdata
);

   localparam int SW = $clog2(NUM_STATES);
   localparam int AW = $clog2(NUM_STATES * NUM_SYMBOLS);
   localparam int RW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
   localparam int PW = $clog2(STACK_DEPTH);
   localparam int TAB_LAST = NUM_STATES * NUM_SYMBOLS - 1;

   function automatic logic [AW-1:0] tab_addr(input logic [SW-1:0] st,
                                              input logic [5:0] sy);
      tab_addr = AW'(st) * AW'(NUM_SYMBOLS) + AW'(sy);
   endfunction

   function automatic logic sym_ok(input logic [5:0] sy);
      sym_ok = 32'(sy) < NUM_SYMBOLS;
   endfunction

   logic [SW:0]   trn_mem [NUM_STATES*NUM_SYMBOLS];
   logic [RW:0]   red_mem [NUM_STATES*NUM_SYMBOLS];
   logic [9:0]    rule_mem [NUM_RULES];
   logic [SW-1:0] stk_mem [STACK_DEPTH];

   state_type       state_ff, state_in, ret_ff, ret_in;
   logic [PW-1:0]   sp_ff, sp_in, below_ff, below_in;
   logic [SW-1:0]   top_ff, top_in;
   logic            err_ff, err_in;
   logic [5:0]      sym_ff, sym_in, lhs_ff, lhs_in, cnt_ff, cnt_in, acc_ff;
   logic [RW-1:0]   rule_ff, rule_in;
   logic [AW-1:0]   clr_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type out_ff, out_in;

   logic [SW:0]     trn_rd_ff, trn_wdata;
   logic [RW:0]     red_rd_ff, red_wdata;
   logic [9:0]      rule_rd_ff;
   logic [SW-1:0]   stk_rd_ff, stk_wdata;
   logic            trn_ok_ff, red_ok_ff, trn_rok, red_rok;
   logic [AW-1:0]   trn_raddr, red_raddr, trn_waddr, red_waddr;
   logic [RW-1:0]   rule_raddr, rule_waddr;
   logic [PW-1:0]   stk_raddr, stk_waddr;
   logic            trn_we, red_we, rule_we, stk_we;

   logic            red_hit, trn_hit, rule_short, sp_full, below_full, cnt_over, end_bad;
   logic [3:0]      len_w;
   logic [SW-1:0]   stk_val;
   logic            req_fire;

   assign req_fire   = req_if.valid && req_if.ready;
   assign red_hit    = red_ok_ff && red_rd_ff[RW];
   assign trn_hit    = trn_ok_ff && trn_rd_ff[SW];
   assign len_w      = rule_rd_ff[3:0];
   assign rule_short = (PW+4)'(len_w) > (PW+4)'(sp_ff);
   assign sp_full    = sp_ff == PW'(STACK_DEPTH - 1);
   assign below_full = below_ff == PW'(STACK_DEPTH - 1);
   assign cnt_over   = 32'(cnt_ff) >= MAX_REDUCTIONS;
   assign end_bad    = err_ff || !red_hit || rule_short;
   assign stk_val    = (below_ff == '0) ? '0 : stk_rd_ff;

   assign req_if.ready = state_ff == ST_IDLE;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(TAB_LAST)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               unique case (req_if.data.mode)
                  MODE_TOKEN:      state_in = err_ff ? ST_OUT_WAIT : ST_RED_DATA;
                  MODE_END:        state_in = ST_END_DATA;
                  MODE_WRITE_TRN,
                  MODE_WRITE_RED,
                  MODE_WRITE_RULE: state_in = ST_OUT_WAIT;
                  default:         state_in = ST_IDLE;
               endcase
            end
         end
         ST_RED_ISSUE: state_in = ST_RED_DATA;
         ST_RED_DATA: begin
            priority if (!red_hit) state_in = ST_SHIFT_DATA;
            else if (cnt_over)     state_in = ST_OUT_WAIT;
            else                   state_in = ST_RULE_DATA;
         end
         ST_RULE_DATA:  state_in = rule_short ? ST_OUT_WAIT : ST_STK_DATA;
         ST_STK_DATA:   state_in = ST_GOTO_DATA;
         ST_GOTO_DATA,
         ST_SHIFT_DATA,
         ST_END_STK,
         ST_END_ACC:    state_in = ST_OUT_WAIT;
         ST_END_DATA:   state_in = end_bad ? ST_OUT_WAIT : ST_END_STK;
         ST_OUT_WAIT: begin
            if (rsp_if.ready) state_in = ret_ff;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ret_in       = ret_ff;
      sp_in        = sp_ff;
      below_in     = below_ff;
      top_in       = top_ff;
      err_in       = err_ff;
      sym_in       = sym_ff;
      lhs_in       = lhs_ff;
      cnt_in       = cnt_ff;
      rule_in      = rule_ff;
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      trn_raddr    = tab_addr(top_ff, sym_ff);
      trn_rok      = sym_ok(sym_ff);
      red_raddr    = tab_addr(top_ff, sym_ff);
      red_rok      = sym_ok(sym_ff);
      rule_raddr   = '0;
      stk_raddr    = '0;
      trn_we       = 1'b0;
      red_we       = 1'b0;
      rule_we      = 1'b0;
      stk_we       = 1'b0;
      trn_waddr    = tab_addr(SW'(req_if.data.state_num), req_if.data.symbol);
      red_waddr    = trn_waddr;
      trn_wdata    = {req_if.data.entry_valid, SW'(req_if.data.target)};
      red_wdata    = {req_if.data.entry_valid, RW'(req_if.data.target)};
      rule_waddr   = RW'(req_if.data.target);
      stk_waddr    = sp_ff + PW'(1);
      stk_wdata    = trn_rd_ff[SW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            trn_we    = 1'b1;
            red_we    = 1'b1;
            trn_waddr = clr_ff;
            red_waddr = clr_ff;
            trn_wdata = '0;
            red_wdata = '0;
         end
         ST_IDLE: begin
            sym_in    = req_if.data.symbol;
            cnt_in    = '0;
            red_raddr = tab_addr(top_ff, (req_if.data.mode == MODE_END) ?
                                 acc_ff : req_if.data.symbol);
            red_rok   = sym_ok((req_if.data.mode == MODE_END) ?
                               acc_ff : req_if.data.symbol);
            out_in    = '{kind: KIND_WRITTEN, rule_number: '0,
                          new_top_state: 9'(top_ff), last: 1'b1};
            ret_in    = ST_IDLE;
            if (req_fire) begin
               unique case (req_if.data.mode)
                  MODE_TOKEN: begin
                     if (err_ff) begin
                        out_in.kind  = KIND_REJECTED;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  MODE_WRITE_TRN: begin
                     trn_we = 32'(req_if.data.state_num) < NUM_STATES &&
                              sym_ok(req_if.data.symbol) &&
                              32'(req_if.data.target) < NUM_STATES;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_WRITE_RED: begin
                     red_we = 32'(req_if.data.state_num) < NUM_STATES &&
                              sym_ok(req_if.data.symbol) &&
                              32'(req_if.data.target) < NUM_RULES;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_WRITE_RULE: begin
                     rule_we      = 32'(req_if.data.target) < NUM_RULES;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RED_ISSUE: begin
         end
         ST_RED_DATA: begin
            rule_raddr = red_rd_ff[RW-1:0];
            rule_in    = red_rd_ff[RW-1:0];
            if (red_hit && cnt_over) begin
               err_in       = 1'b1;
               rsp_valid_in = 1'b1;
               out_in       = '{kind: KIND_REJECTED, rule_number: '0,
                                new_top_state: 9'(top_ff), last: 1'b1};
               ret_in       = ST_IDLE;
            end
         end
         ST_RULE_DATA: begin
            stk_raddr = sp_ff - PW'(len_w);
            below_in  = sp_ff - PW'(len_w);
            lhs_in    = rule_rd_ff[9:4];
            if (rule_short) begin
               err_in       = 1'b1;
               rsp_valid_in = 1'b1;
               out_in       = '{kind: KIND_REJECTED, rule_number: '0,
                                new_top_state: 9'(top_ff), last: 1'b1};
               ret_in       = ST_IDLE;
            end
         end
         ST_STK_DATA: begin
            trn_raddr = tab_addr(stk_val, lhs_ff);
            trn_rok   = sym_ok(lhs_ff);
         end
         ST_GOTO_DATA: begin
            rsp_valid_in = 1'b1;
            if (!trn_hit || below_full) begin
               err_in = 1'b1;
               out_in = '{kind: KIND_REJECTED, rule_number: '0,
                          new_top_state: 9'(top_ff), last: 1'b1};
               ret_in = ST_IDLE;
            end else begin
               stk_we    = 1'b1;
               stk_waddr = below_ff + PW'(1);
               sp_in     = below_ff + PW'(1);
               top_in    = trn_rd_ff[SW-1:0];
               cnt_in    = cnt_ff + 6'd1;
               out_in    = '{kind: KIND_REDUCED, rule_number: 7'(rule_ff),
                             new_top_state: 9'(trn_rd_ff[SW-1:0]), last: 1'b0};
               ret_in    = ST_RED_ISSUE;
            end
         end
         ST_SHIFT_DATA: begin
            rsp_valid_in = 1'b1;
            ret_in       = ST_IDLE;
            if (!trn_hit || sp_full) begin
               err_in = 1'b1;
               out_in = '{kind: KIND_REJECTED, rule_number: '0,
                          new_top_state: 9'(top_ff), last: 1'b1};
            end else begin
               stk_we = 1'b1;
               sp_in  = sp_ff + PW'(1);
               top_in = trn_rd_ff[SW-1:0];
               out_in = '{kind: KIND_SHIFTED, rule_number: '0,
                          new_top_state: 9'(trn_rd_ff[SW-1:0]), last: 1'b1};
            end
         end
         ST_END_DATA: begin
            stk_raddr = sp_ff - PW'(len_w);
            below_in  = sp_ff - PW'(len_w);
            if (end_bad) begin
               rsp_valid_in = 1'b1;
               out_in       = '{kind: KIND_REJECTED, rule_number: '0,
                                new_top_state: 9'(top_ff), last: 1'b1};
               ret_in       = ST_IDLE;
               sp_in        = '0;
               top_in       = '0;
               err_in       = 1'b0;
            end
         end
         ST_END_STK: begin
            rsp_valid_in = 1'b1;
            sp_in        = below_ff;
            top_in       = stk_val;
            out_in       = '{kind: KIND_REDUCED, rule_number: '0,
                             new_top_state: 9'(stk_val), last: 1'b0};
            ret_in       = ST_END_ACC;
         end
         ST_END_ACC: begin
            rsp_valid_in = 1'b1;
            out_in       = '{kind: KIND_ACCEPTED, rule_number: '0,
                             new_top_state: 9'(top_ff), last: 1'b1};
            ret_in       = ST_IDLE;
            sp_in        = '0;
            top_in       = '0;
            err_in       = 1'b0;
         end
         ST_OUT_WAIT: begin
            if (rsp_if.ready) rsp_valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      trn_rd_ff  <= trn_mem[trn_raddr];
      red_rd_ff  <= red_mem[red_raddr];
      rule_rd_ff <= rule_mem[rule_raddr];
      stk_rd_ff  <= stk_mem[stk_raddr];
      trn_ok_ff  <= trn_rok;
      red_ok_ff  <= red_rok;
      if (trn_we) trn_mem[trn_waddr] <= trn_wdata;
      if (red_we) red_mem[red_waddr] <= red_wdata;
      if (rule_we) rule_mem[rule_waddr] <= {req_if.data.rule_lhs, req_if.data.rule_length};
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
   end

   always_ff @(posedge clock) begin
      below_ff <= below_in;
      sym_ff   <= sym_in;
      lhs_ff   <= lhs_in;
      cnt_ff   <= cnt_in;
      rule_ff  <= rule_in;
      out_ff   <= out_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_IDLE;
         sp_ff        <= '0;
         top_ff       <= '0;
         err_ff       <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= ACCEPT_SYMBOL_RESET;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         sp_ff        <= sp_in;
         top_ff       <= top_in;
         err_ff       <= err_in;
         clr_ff       <= clr_ff + AW'(1);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) acc_ff <= csr_wdata;
      end
   end

   a_valid_only_waiting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_OUT_WAIT)
      else $error("response valid outside wait state");

   a_no_request_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_if.ready)
      else $error("request taken during table clear");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= MAX_REDUCTIONS)
      else $error("reduction count past limit");

   a_goto_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GOTO_DATA && trn_hit && !below_full)
      |=> sp_ff == $past(below_ff) + PW'(1))
      else $error("goto push lost stack position");

endmodule
